@@ hw/rtl/vrt_pkg.sv @@
package vrt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIVE_W   = 4;

  localparam logic [CMD_W-1:0] CMD_PUBLISH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEWEST,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

endpackage

@@ hw/rtl/version_refcount_table.sv @@
// Publish and acquire: accepted in S_IDLE, result registered from S_NEWEST; the next item is
// taken in the same cycle that the result appears. Release: one S_SCAN step per entry scanned
// up to the oldest match, one S_SHIFT step per entry moved down when the match is retired.
// Empty-list cases and unused commands finish in S_IDLE. A stalled result holds the
// next item back until it is taken.
// Reset clears the entry count and the control state; the entry memory is not cleared.
module version_refcount_table #(
  parameter int unsigned VERSION_SLOTS = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [vrt_pkg::CMD_W-1:0]    command_i,
  input  logic [vrt_pkg::HANDLE_W-1:0] handle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vrt_pkg::STATUS_W-1:0] status_o,
  output logic [vrt_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                         freed_o,
  output logic [vrt_pkg::HANDLE_W-1:0] freed_handle_o,
  output logic [vrt_pkg::LIVE_W-1:0]   live_entries_o
);

  import vrt_pkg::*;

  localparam int unsigned IW = $clog2(VERSION_SLOTS);
  localparam int unsigned TW = $clog2(VERSION_SLOTS + 1);
  localparam int unsigned DW = HANDLE_W + COUNT_BITS;

  state_e              state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [HANDLE_W-1:0] hdl_q, hdl_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [TW-1:0]       total_q, total_d;
  logic [HANDLE_W-1:0] fh_q, fh_d;

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic [DW-1:0]       rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;

  logic [HANDLE_W-1:0]   rd_hdl;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] dec_cnt;
  logic [TW-1:0]         last_idx;
  logic [TW-1:0]         idx_p1;
  logic [TW-1:0]         idx_p2;
  logic                  full;

  logic                fin;
  logic [STATUS_W-1:0] f_status;
  logic [HANDLE_W-1:0] f_oh;
  logic                f_fr;
  logic [HANDLE_W-1:0] f_fh;
  logic [LIVE_W-1:0]   f_live;
  logic                out_free;
  logic                out_load;
  logic                res_load;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [HANDLE_W-1:0] out_oh_q;
  logic                out_fr_q;
  logic [HANDLE_W-1:0] out_fh_q;
  logic [LIVE_W-1:0]   out_live_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [HANDLE_W-1:0] res_oh_q;
  logic                res_fr_q;
  logic [HANDLE_W-1:0] res_fh_q;
  logic [LIVE_W-1:0]   res_live_q;

  vrt_store #(
    .DEPTH (VERSION_SLOTS),
    .DW    (DW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign rd_hdl   = rd_data[COUNT_BITS +: HANDLE_W];
  assign rd_cnt   = rd_data[COUNT_BITS-1:0];
  assign dec_cnt  = (rd_cnt != '0) ? rd_cnt - COUNT_BITS'(1) : '0;
  assign last_idx = total_q - TW'(1);
  assign idx_p1   = TW'(idx_q) + TW'(1);
  assign idx_p2   = TW'(idx_q) + TW'(2);
  assign full     = (total_q >= TW'(VERSION_SLOTS));
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    hdl_d    = hdl_q;
    idx_d    = idx_q;
    total_d  = total_q;
    fh_d     = fh_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    fin      = 1'b0;
    f_status = STAT_OK;
    f_oh     = '0;
    f_fr     = 1'b0;
    f_fh     = '0;
    out_load = 1'b0;
    res_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = command_i;
          hdl_d = handle_i;
          case (command_i) inside
            CMD_PUBLISH, CMD_ACQUIRE: begin
              if (total_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = IW'(last_idx);
                state_d = S_NEWEST;
              end else if (command_i == CMD_PUBLISH) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {handle_i, COUNT_BITS'(0)};
                total_d = TW'(1);
                fin     = 1'b1;
              end else begin
                f_status = STAT_EMPTY;
                fin      = 1'b1;
              end
            end
            CMD_RELEASE: begin
              if (total_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
                state_d = S_SCAN;
              end else begin
                f_status = STAT_NOT_FOUND;
                fin      = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_NEWEST: begin
        fin = 1'b1;
        if (cmd_q == CMD_PUBLISH) begin
          if (rd_cnt == '0) begin
            wr_en   = 1'b1;
            wr_addr = IW'(last_idx);
            wr_data = {hdl_q, COUNT_BITS'(0)};
            f_fr    = 1'b1;
            f_fh    = rd_hdl;
          end else if (full) begin
            f_status = STAT_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = IW'(total_q);
            wr_data = {hdl_q, COUNT_BITS'(0)};
            total_d = total_q + TW'(1);
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = IW'(last_idx);
          wr_data = {rd_hdl, (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1)};
          f_oh    = rd_hdl;
        end
      end
      S_SCAN: begin
        if (rd_hdl == hdl_q) begin
          if (idx_p1 != total_q && dec_cnt == '0) begin
            // retire: close up the list from the next entry on
            fh_d    = rd_hdl;
            rd_en   = 1'b1;
            rd_addr = IW'(idx_p1);
            state_d = S_SHIFT;
          end else begin
            wr_en   = 1'b1;
            wr_addr = idx_q;
            wr_data = {rd_hdl, dec_cnt};
            fin     = 1'b1;
          end
        end else if (idx_p1 == total_q) begin
          f_status = STAT_NOT_FOUND;
          fin      = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_p1);
          idx_d   = IW'(idx_p1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data;
        if (idx_p2 == total_q) begin
          total_d = last_idx;
          f_fr    = 1'b1;
          f_fh    = fh_q;
          fin     = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_p2);
          idx_d   = IW'(idx_p1);
        end
      end
      S_RESULT: begin
        fin      = 1'b1;
        f_status = res_status_q;
        f_oh     = res_oh_q;
        f_fr     = res_fr_q;
        f_fh     = res_fh_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    f_live = (state_q == S_RESULT) ? res_live_q : LIVE_W'(total_d);

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        state_d  = S_IDLE;
      end else begin
        state_d  = S_RESULT;
        res_load = (state_q != S_RESULT);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    hdl_q <= hdl_d;
    idx_q <= idx_d;
    fh_q  <= fh_d;
    if (res_load) begin
      res_status_q <= f_status;
      res_oh_q     <= f_oh;
      res_fr_q     <= f_fr;
      res_fh_q     <= f_fh;
      res_live_q   <= f_live;
    end
    if (out_load) begin
      out_status_q <= f_status;
      out_oh_q     <= f_oh;
      out_fr_q     <= f_fr;
      out_fh_q     <= f_fh;
      out_live_q   <= f_live;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_handle_o   = out_oh_q;
  assign freed_o        = out_fr_q;
  assign freed_handle_o = out_fh_q;
  assign live_entries_o = out_live_q;

endmodule

@@ hw/rtl/vrt_store.sv @@
module vrt_store #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned DW    = 48
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DW-1:0]            rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DW-1:0]            wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ verif/tb.sv @@
module tb;
  import vrt_pkg::*;

  localparam int SLOTS          = 8;
  localparam int REF_BITS       = 16;
  localparam int POOL_SIZE      = 12;
  localparam int PHASE_ITEMS    = 412;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic                freed;
    logic [HANDLE_W-1:0] freed_handle;
    logic [LIVE_W-1:0]   live;
  } reply_t;

  class version_list_tracker;
    logic [HANDLE_W-1:0] slot_handle [SLOTS];
    logic [REF_BITS-1:0] slot_refs [SLOTS];
    int                  slot_count;
    reply_t              pending_replies [$];
    int                  errors;

    function new();
      slot_count = 0;
      errors     = 0;
      foreach (slot_refs[i]) begin
        slot_refs[i]   = '0;
        slot_handle[i] = '0;
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h);
      reply_t r;
      int     hit;
      int     i;
      r.status       = STAT_OK;
      r.out_handle   = '0;
      r.freed        = 1'b0;
      r.freed_handle = '0;
      case (cmd)
        CMD_PUBLISH: begin
          if (slot_count > 0 && slot_refs[slot_count-1] == '0) begin
            r.freed                   = 1'b1;
            r.freed_handle            = slot_handle[slot_count-1];
            slot_handle[slot_count-1] = h;
          end else if (slot_count >= SLOTS) begin
            r.status = STAT_FULL;
          end else begin
            slot_handle[slot_count] = h;
            slot_refs[slot_count]   = '0;
            slot_count++;
          end
        end
        CMD_ACQUIRE: begin
          if (slot_count == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            if (slot_refs[slot_count-1] != '1) slot_refs[slot_count-1]++;
            r.out_handle = slot_handle[slot_count-1];
          end
        end
        CMD_RELEASE: begin
          hit = -1;
          for (i = slot_count - 1; i >= 0; i--) begin
            if (slot_handle[i] == h) hit = i;
          end
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            if (slot_refs[hit] != '0) slot_refs[hit]--;
            if (hit + 1 != slot_count && slot_refs[hit] == '0) begin
              r.freed        = 1'b1;
              r.freed_handle = slot_handle[hit];
              for (i = hit; i + 1 < slot_count; i++) begin
                slot_handle[i] = slot_handle[i+1];
                slot_refs[i]   = slot_refs[i+1];
              end
              slot_count--;
            end
          end
        end
        default: ;
      endcase
      r.live = slot_count[LIVE_W-1:0];
      pending_replies.insert(pending_replies.size(), r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("tb: unexpected reply st=%0d oh=%h fr=%0b fh=%h live=%0d",
                   got.status, got.out_handle, got.freed, got.freed_handle, got.live);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.out_handle !== want.out_handle ||
          got.freed !== want.freed || got.freed_handle !== want.freed_handle ||
          got.live !== want.live) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("tb: mismatch exp st=%0d oh=%h fr=%0b fh=%h live=%0d",
                   want.status, want.out_handle, want.freed, want.freed_handle, want.live);
          $display("tb:          act st=%0d oh=%h fr=%0b fh=%h live=%0d",
                   got.status, got.out_handle, got.freed, got.freed_handle, got.live);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i    = CMD_PUBLISH;
  logic [HANDLE_W-1:0] handle_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic                freed_o;
  logic [HANDLE_W-1:0] freed_handle_o;
  logic [LIVE_W-1:0]   live_entries_o;

  version_list_tracker tracker = new();
  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  quiet_cycles   = 0;

  version_refcount_table #(
    .VERSION_SLOTS(SLOTS),
    .COUNT_BITS   (REF_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .handle_i      (handle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_handle_o  (out_handle_o),
    .freed_o       (freed_o),
    .freed_handle_o(freed_handle_o),
    .live_entries_o(live_entries_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_reply('{status_o, out_handle_o, freed_o, freed_handle_o, live_entries_o});
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Entered and left at a falling edge; valid stays high into the next item.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    handle_i   <= h;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_command(cmd, h);
    @(negedge clk_i);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_phase(input int count);
    int                  roll;
    logic [HANDLE_W-1:0] h;
    repeat (count) begin
      roll = $urandom_range(99);
      h    = $urandom;
      if (roll < 34) begin
        if ($urandom_range(3) != 0) h = handle_pool[$urandom_range(POOL_SIZE-1)];
        send_item(CMD_PUBLISH, h);
      end else if (roll < 64) begin
        send_item(CMD_ACQUIRE, h);
      end else if (roll < 95) begin
        roll = $urandom_range(99);
        if (tracker.slot_count > 0 && roll < 70)
          h = tracker.slot_handle[$urandom_range(tracker.slot_count-1)];
        else if (roll < 90)
          h = handle_pool[$urandom_range(POOL_SIZE-1)];
        send_item(CMD_RELEASE, h);
      end else begin
        send_item(CMD_SPARE, h);
      end
      if ($urandom_range(99) == 0) drain_replies();
    end
  endtask

  initial begin
    int k;
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) handle_pool[k] = $urandom;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(CMD_ACQUIRE, '0);
    send_item(CMD_RELEASE, 32'h1234_5678);
    send_item(CMD_SPARE, '1);
    send_item(CMD_PUBLISH, '0);
    send_item(CMD_PUBLISH, '1);
    send_item(CMD_ACQUIRE, 32'h5555_5555);
    send_item(CMD_RELEASE, '1);
    send_item(CMD_RELEASE, '1);
    send_item(CMD_ACQUIRE, 32'hAAAA_AAAA);
    for (k = 2; k < 9; k++) begin
      send_item(CMD_PUBLISH, handle_pool[k]);
      send_item(CMD_ACQUIRE, '0);
    end
    send_item(CMD_PUBLISH, 32'hA5A5_5A5A);
    send_item(CMD_RELEASE, '1);
    // duplicate handle: release hits the older copy
    send_item(CMD_PUBLISH, handle_pool[2]);
    send_item(CMD_ACQUIRE, '0);
    send_item(CMD_RELEASE, handle_pool[2]);
    drain_replies();

    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      random_phase(PHASE_ITEMS);
      drain_replies();
    end

    repeat (40) @(negedge clk_i);
    tracker.errors += tracker.pending_replies.size();
    if (tracker.errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
